// ===== rtl/gdcc_pkg.sv =====
// Shared constants, codes and types for the gated depthwise causal convolution block.
// Depends on nothing; every other file but gdcc_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package gdcc_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int MAX_CHANNELS = 256;
  localparam int MAX_TAPS     = 4;
  localparam int MIN_TAPS     = 2;
  localparam int HIST_DEPTH   = MAX_TAPS - 1;

  localparam int CH_W        = 8;
  localparam int TAP_W       = $clog2(MAX_TAPS);
  localparam int CHANS_CFG_W = 9;
  localparam int TAPS_CFG_W  = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;

  localparam int CH_ADDR_W = $clog2(MAX_CHANNELS);
  localparam int WT_DEPTH  = MAX_CHANNELS * MAX_TAPS;
  localparam int WT_ADDR_W = $clog2(WT_DEPTH);
  localparam int HIST_W    = HIST_DEPTH * DATA_WIDTH;

  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int GATE_RND_W = PROD_W + 1 - FRAC_BITS;
  localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int ACC_RND_W  = ACC_W - FRAC_BITS;
  localparam int MUL_W      = DATA_WIDTH + ACC_RND_W;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS = 1'b0,
    CFG_TAPS     = 1'b1
  } gdcc_cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_TAP,
    ST_ACC,
    ST_SCALE,
    ST_DONE
  } gdcc_state_t;

  typedef enum logic [1:0] {
    OP_GATE,
    OP_TAP,
    OP_SCALE
  } gdcc_op_t;

  typedef struct packed {
    gdcc_op_t         op;
    logic             mul_en;
    logic             acc_init;
    logic             acc_add;
    logic             bx_load;
    logic             use_bx;
    logic             finish;
    logic [TAP_W-1:0] tap;
  } gdcc_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gdcc_in_if.sv =====
// Input channel interface: valid/ready handshake plus one input transaction.
// Depends on gdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gdcc_in_if import gdcc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [CH_W-1:0]              channel;
  logic [TAP_W-1:0]             tap;
  logic signed [DATA_WIDTH-1:0] weight;
  logic signed [DATA_WIDTH-1:0] gate_in;
  logic signed [DATA_WIDTH-1:0] gate_out;
  logic signed [DATA_WIDTH-1:0] sample;

  modport source (
    output valid, func, channel, tap, weight, gate_in, gate_out, sample,
    input  ready
  );
  modport sink (
    input  valid, func, channel, tap, weight, gate_in, gate_out, sample,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/gdcc_out_if.sv =====
// Result channel interface: valid/ready handshake plus one result transaction.
// Depends on gdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gdcc_out_if import gdcc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic [CH_W-1:0]              out_channel;
  logic                         saturated;

  modport source (
    output valid, out_value, out_channel, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_value, out_channel, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/gdcc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module gdcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gdcc_seq.sv =====
// Sequencer: steps one sample transaction through gate, taps, accumulate, scale, done.
// Depends on gdcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdcc_seq import gdcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TAP_W-1:0] hist_len,
  input  logic             out_free,
  output logic             idle,
  output gdcc_ctrl_t       ctrl
);

  gdcc_state_t      state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             last_tap;

  assign last_tap = (tap_r == hist_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_GATE;
        end
      end
      ST_GATE: begin
        state_nxt = ST_TAP;
        tap_nxt   = '0;
      end
      ST_TAP: begin
        if (last_tap) begin
          state_nxt = ST_ACC;
        end else begin
          tap_nxt = tap_r + TAP_W'(1);
        end
      end
      ST_ACC: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl     = '0;
    ctrl.op  = OP_GATE;
    ctrl.tap = tap_r;
    idle     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
      end
      ST_GATE: begin
        ctrl.mul_en = 1'b1;
      end
      ST_TAP: begin
        ctrl.op       = OP_TAP;
        ctrl.mul_en   = 1'b1;
        ctrl.acc_init = (tap_r == '0);
        ctrl.acc_add  = (tap_r != '0);
        ctrl.bx_load  = (tap_r == '0);
        ctrl.use_bx   = last_tap;
      end
      ST_ACC: begin
        ctrl.acc_add = 1'b1;
      end
      ST_SCALE: begin
        ctrl.op     = OP_SCALE;
        ctrl.mul_en = 1'b1;
      end
      ST_DONE: begin
        ctrl.finish = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gdcc_mac.sv =====
// Shared multiplier, accumulator and round/saturate logic for one sample transaction.
// Depends on gdcc_pkg; steered by the gdcc_seq control struct.
`timescale 1ns / 1ps
`default_nettype none

module gdcc_mac import gdcc_pkg::*; (
  input  logic                         clk,
  input  gdcc_ctrl_t                   ctrl,
  input  logic signed [DATA_WIDTH-1:0] gate_in,
  input  logic signed [DATA_WIDTH-1:0] sample,
  input  logic signed [DATA_WIDTH-1:0] gate_out,
  input  logic signed [DATA_WIDTH-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0] hist_tap,
  output logic signed [DATA_WIDTH-1:0] bx,
  output logic                         bx_clip,
  output logic signed [DATA_WIDTH-1:0] y,
  output logic                         y_clip
);

  logic signed [DATA_WIDTH-1:0] op_a;
  logic signed [ACC_RND_W-1:0]  op_b;
  logic signed [MUL_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [DATA_WIDTH-1:0] bx_r;
  logic                         bx_clip_r;

  logic signed [PROD_W:0]               gate_sum;
  logic signed [GATE_RND_W-1:0]         gate_rnd;
  logic signed [DATA_WIDTH-1:0]         bx_nxt;
  logic                                 bx_clip_nxt;
  logic signed [MUL_W-1:0]              fin_sum;
  logic signed [MUL_W-FRAC_BITS-1:0]    fin_rnd;

  always_comb begin
    unique case (ctrl.op)
      OP_GATE: begin
        op_a = gate_in;
        op_b = ACC_RND_W'(sample);
      end
      OP_TAP: begin
        op_a = weight;
        op_b = ctrl.use_bx ? ACC_RND_W'(bx_r) : ACC_RND_W'(hist_tap);
      end
      OP_SCALE: begin
        op_a = gate_out;
        op_b = $signed(acc_r[ACC_W-1:FRAC_BITS]);
      end
      default: begin
        op_a = gate_in;
        op_b = ACC_RND_W'(sample);
      end
    endcase
  end

  // round half up, then clip the gated sample
  always_comb begin
    gate_sum    = (PROD_W+1)'($signed(prod_r[PROD_W-1:0])) + (PROD_W+1)'(ROUND_HALF);
    gate_rnd    = gate_sum[PROD_W:FRAC_BITS];
    bx_clip_nxt = 1'b0;
    if (gate_rnd > DATA_MAX) begin
      bx_nxt      = DATA_MAX;
      bx_clip_nxt = 1'b1;
    end else if (gate_rnd < DATA_MIN) begin
      bx_nxt      = DATA_MIN;
      bx_clip_nxt = 1'b1;
    end else begin
      bx_nxt = DATA_WIDTH'(gate_rnd);
    end
  end

  always_comb begin
    fin_sum = prod_r + MUL_W'(ROUND_HALF);
    fin_rnd = fin_sum[MUL_W-1:FRAC_BITS];
    y_clip  = 1'b0;
    if (fin_rnd > DATA_MAX) begin
      y      = DATA_MAX;
      y_clip = 1'b1;
    end else if (fin_rnd < DATA_MIN) begin
      y      = DATA_MIN;
      y_clip = 1'b1;
    end else begin
      y = DATA_WIDTH'(fin_rnd);
    end
  end

  // accumulator starts at half an LSB so the final shift rounds
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.acc_init) begin
      acc_r <= ACC_W'(ROUND_HALF);
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctrl.bx_load) begin
      bx_r      <= bx_nxt;
      bx_clip_r <= bx_clip_nxt;
    end
  end

  assign bx      = bx_r;
  assign bx_clip = bx_clip_r;

endmodule

`default_nettype wire

// ===== rtl/gated_depthwise_causal_conv_top.sv =====
// Top level: config registers, transaction capture, weight and history RAMs, result register.
// Depends on gdcc_pkg, gdcc_in_if, gdcc_out_if, gdcc_ram, gdcc_seq and gdcc_mac.
//
//   port    dir  width       role
//   in_ch   in   1+8+2+4x16  weight write (func 0) or sample (func 1), valid/ready
//   out_ch  out  16+8+1      gated filter result, valid/ready
//   cfg_*   in   1+1+9       register write: channels_in_use, taps_in_use
//
// On a weight write, in_ch.ready stays high.
// A sample steps through gate, taps, accumulate, scale and done into the result register, then
// ready returns: one shared 16x23 multiplier handles gate_in, each tap and gate_out in turn.
// Reset (rst_n low, synchronous) clears the per-channel history valid bits at once.
// A full result register that is not taken holds the sequencer in its done state.
`timescale 1ns / 1ps
`default_nettype none

module gated_depthwise_causal_conv_top import gdcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gdcc_in_if.sink               in_ch,
  gdcc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CHANS_CFG_W-1:0] chans_r;
  logic [TAPS_CFG_W-1:0]  taps_r;
  logic [TAPS_CFG_W-1:0]  taps_act;
  logic [TAP_W-1:0]       hist_len;

  logic in_acc, ch_ok, tap_ok, wt_we, start, idle, out_free;
  gdcc_ctrl_t ctrl;

  logic [CH_W-1:0]              ch_r;
  logic signed [DATA_WIDTH-1:0] gate_in_r, gate_out_r, sample_r;

  logic [WT_ADDR_W-1:0]  wt_waddr, wt_raddr;
  logic [TAP_W-1:0]      wt_rd_tap;
  logic [DATA_WIDTH-1:0] wt_rdata;

  logic [CH_ADDR_W-1:0]                   hist_addr;
  logic [HIST_W-1:0]                      hist_rdata;
  logic [MAX_CHANNELS-1:0]                hist_vld_r;
  logic                                   row_vld;
  logic [HIST_DEPTH-1:0][DATA_WIDTH-1:0]  hist_row, hist_up, hist_new;
  logic signed [DATA_WIDTH-1:0]           hist_tap;

  logic signed [DATA_WIDTH-1:0] bx, y;
  logic                         bx_clip, y_clip;

  logic                         out_vld_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic [CH_W-1:0]              out_channel_r;
  logic                         out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r <= CHANS_CFG_W'(MAX_CHANNELS);
      taps_r  <= TAPS_CFG_W'(3);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_CHANNELS) begin
        chans_r <= cfg_wdata[CHANS_CFG_W-1:0];
      end
      if (cfg_idx == CFG_TAPS) begin
        taps_r <= cfg_wdata[TAPS_CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (taps_r < TAPS_CFG_W'(MIN_TAPS)) begin
      taps_act = TAPS_CFG_W'(MIN_TAPS);
    end else if (taps_r > TAPS_CFG_W'(MAX_TAPS)) begin
      taps_act = TAPS_CFG_W'(MAX_TAPS);
    end else begin
      taps_act = taps_r;
    end
  end
  assign hist_len = TAP_W'(taps_act - TAPS_CFG_W'(1));

  assign in_ch.ready = idle;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign ch_ok  = (CHANS_CFG_W'(in_ch.channel) < chans_r) &&
                  (int'(in_ch.channel) < MAX_CHANNELS);
  assign tap_ok = (TAPS_CFG_W'(in_ch.tap) < taps_act);
  assign wt_we  = in_acc && (in_ch.func == FUNC_WEIGHT) && ch_ok && tap_ok;
  assign start  = in_acc && (in_ch.func == FUNC_SAMPLE) && ch_ok;

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r       <= in_ch.channel;
      gate_in_r  <= in_ch.gate_in;
      gate_out_r <= in_ch.gate_out;
      sample_r   <= in_ch.sample;
    end
  end

  assign wt_waddr  = WT_ADDR_W'(in_ch.channel) * WT_ADDR_W'(MAX_TAPS) + WT_ADDR_W'(in_ch.tap);
  assign wt_rd_tap = (ctrl.op == OP_GATE) ? '0 : ctrl.tap + TAP_W'(1);
  assign wt_raddr  = WT_ADDR_W'(ch_r) * WT_ADDR_W'(MAX_TAPS) + WT_ADDR_W'(wt_rd_tap);

  gdcc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (WT_DEPTH)
  ) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (in_ch.weight),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  assign hist_addr = CH_ADDR_W'(ch_r);

  gdcc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ctrl.finish),
    .waddr (hist_addr),
    .wdata (hist_new),
    .raddr (hist_addr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (ctrl.finish) begin
      hist_vld_r[hist_addr] <= 1'b1;
    end
  end

  assign row_vld  = hist_vld_r[hist_addr];
  assign hist_row = row_vld ? hist_rdata : '0;
  assign hist_up  = hist_row >> DATA_WIDTH;

  always_comb begin
    hist_tap = '0;
    for (int j = 0; j < HIST_DEPTH; j++) begin
      if (TAP_W'(j) == ctrl.tap) begin
        hist_tap = hist_row[j];
      end
    end
  end

  // slide the active slots, append the gated sample, keep unused slots
  always_comb begin
    for (int j = 0; j < HIST_DEPTH; j++) begin
      if (j + 1 < int'(hist_len)) begin
        hist_new[j] = hist_up[j];
      end else if (j + 1 == int'(hist_len)) begin
        hist_new[j] = bx;
      end else begin
        hist_new[j] = hist_row[j];
      end
    end
  end

  gdcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .hist_len (hist_len),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  gdcc_mac u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .gate_in  (gate_in_r),
    .sample   (sample_r),
    .gate_out (gate_out_r),
    .weight   (wt_rdata),
    .hist_tap (hist_tap),
    .bx       (bx),
    .bx_clip  (bx_clip),
    .y        (y),
    .y_clip   (y_clip)
  );

  assign out_free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_value_r   <= y;
      out_channel_r <= ch_r;
      out_sat_r     <= y_clip || bx_clip;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.out_channel = out_channel_r;
  assign out_ch.saturated   = out_sat_r;

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("ready stayed high after a sample transaction started");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> (!out_vld_r || out_ch.ready))
    else $error("result loaded while the result register was still full");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> (out_ch.valid && out_ch.out_channel == $past(ch_r)))
    else $error("finished transaction did not show up on the result channel");
`endif

endmodule

`default_nettype wire
